// ===== sv/bsp_pkg.sv =====
// shared types, widths and constants of the billboard sprite projection core
package bsp_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CW           = 28;   // cordic x/y width
    localparam int ZW           = 26;   // cordic angle width
    localparam int QB           = 25;   // quotient bits
    localparam int DQ_W         = 25;   // positive depth magnitude bits
    localparam int DW           = 36;   // divisor width

    localparam logic [23:0] HALF24 = 24'd8388608;
    localparam logic signed [ZW-1:0] ANG_HALF_Z    = ZW'(8388608);
    localparam logic signed [ZW-1:0] ANG_QUARTER_Z = ZW'(4194304);
    localparam logic signed [16:0] INV_GAIN = 17'sd39797;

    localparam logic [11:0] RST_HSW = 12'd800;
    localparam logic [11:0] RST_HSH = 12'd450;
    localparam logic [15:0] RST_SD  = 16'd22170;
    localparam logic [11:0] RST_HRC = 12'd400;
    localparam logic [15:0] RST_RPT = 16'd4800;
    localparam logic [15:0] RST_PPR = 16'd512;

    typedef enum logic [2:0] {
        CFG_HSW = 3'd0,
        CFG_HSH = 3'd1,
        CFG_SD  = 3'd2,
        CFG_HRC = 3'd3,
        CFG_RPT = 3'd4,
        CFG_PPR = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic               vis;
        logic [15:0]        head;
        logic [10:0]        tw;
        logic [10:0]        th;
        logic [15:0]        ts;
        logic signed [15:0] shift;
        logic [7:0]         tag;
        logic signed [24:0] d;
        logic signed [44:0] dq_mul;
        logic [31:0]        sdts;
        logic signed [28:0] dq18;
        logic signed [41:0] drpt;
        logic [52:0]        nw;
        logic signed [42:0] acc;
        logic [DW-1:0]      den;
        logic signed [38:0] hi_p;
        logic [36:0]        lo_p;
        logic signed [35:0] hx8;
    } t_side;

    typedef struct packed {
        logic signed [CW-1:0] vx;
        logic signed [CW-1:0] vy;
        logic signed [ZW-1:0] vz;
        logic signed [CW-1:0] rx;
        logic signed [CW-1:0] ry;
        logic signed [ZW-1:0] rz;
        t_side                side;
    } t_cordic;

    typedef struct packed {
        logic [DW-1:0] ph;
        logic [DW-1:0] pw;
        logic [QB-1:0] nh;
        logic [QB-1:0] nl;
        logic [QB-1:0] qh;
        logic [QB-1:0] qw;
        logic          ovf;
        t_side         side;
    } t_div;

    // arctangent of 2^-i in 2^24 units per turn
    function automatic logic signed [ZW-1:0] atan_turn(input logic [4:0] i);
        logic [21:0] a;
        case (i)
            5'd0:  a = 22'd2097152;
            5'd1:  a = 22'd1238021;
            5'd2:  a = 22'd654136;
            5'd3:  a = 22'd332050;
            5'd4:  a = 22'd166669;
            5'd5:  a = 22'd83416;
            5'd6:  a = 22'd41718;
            5'd7:  a = 22'd20860;
            5'd8:  a = 22'd10430;
            5'd9:  a = 22'd5215;
            5'd10: a = 22'd2608;
            5'd11: a = 22'd1304;
            5'd12: a = 22'd652;
            5'd13: a = 22'd326;
            5'd14: a = 22'd163;
            5'd15: a = 22'd81;
            5'd16: a = 22'd41;
            5'd17: a = 22'd20;
            5'd18: a = 22'd10;
            5'd19: a = 22'd5;
            5'd20: a = 22'd3;
            5'd21: a = 22'd1;
            5'd22: a = 22'd1;
            default: a = 22'd0;
        endcase
        return $signed({{(ZW-22){1'b0}}, a});
    endfunction

    function automatic logic [13:0] sat_s14(input logic signed [28:0] v);
        if (v < -29'sd8192) begin
            return 14'h2000;
        end else if (v > 29'sd8191) begin
            return 14'h1FFF;
        end else begin
            return v[13:0];
        end
    endfunction

endpackage

// ===== sv/billboard_sprite_projection_core.sv =====
// top level of the billboard sprite projection core
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata 136b query, tuser 8b tag
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata 72b sprite box, tuser 8b tag
//  cfg       in   i_cfg_valid / o_cfg_ready      i_cfg_index 3b, i_cfg_data 16b
//
// one query per cycle while the pipeline is not frozen
// 49 register stages: input, 16 cordic cells, 4 post, divider seed, 25 divider cells,
// final and output; the input stage loads at the accepting edge itself
// synchronous active-low reset clears all valid bits and loads register defaults
// the whole pipeline freezes only when the last stage holds a visible sprite
// and the output register is full and not taken
// queries that land off screen or too close drop out and leave no transaction
module billboard_sprite_projection_core import bsp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // sprite_x, sprite_y, viewer_x, viewer_y, viewer_heading, tex_width,
    // tex_height, tex_scale, vertical_shift, 2 zero bits
    input  logic [135:0] s_axis_tdata,
    // sprite_tag
    input  logic [7:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // depth, left_x, top_y, proj_width, proj_height
    output logic [71:0]  m_axis_tdata,
    // out_tag
    output logic [7:0]   m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);
    // configuration registers
    logic [11:0] r_hsw, r_hsh, r_hrc;
    logic [15:0] r_sd, r_rpt, r_ppr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hsw <= RST_HSW;
            r_hsh <= RST_HSH;
            r_sd  <= RST_SD;
            r_hrc <= RST_HRC;
            r_rpt <= RST_RPT;
            r_ppr <= RST_PPR;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_HSW: r_hsw <= i_cfg_data[11:0];
                CFG_HSH: r_hsh <= i_cfg_data[11:0];
                CFG_SD:  r_sd  <= i_cfg_data;
                CFG_HRC: r_hrc <= i_cfg_data[11:0];
                CFG_RPT: r_rpt <= i_cfg_data;
                CFG_PPR: r_ppr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: hold only when a visible result cannot leave
    logic en, keep;
    logic r_out_valid;

    // ------------------------------------------------------------------
    // input stage: offsets, half-turn folds, cordic seeds
    // ------------------------------------------------------------------
    t_cordic              n_c0;
    logic signed [16:0]   dx, dy;
    logic signed [CW-1:0] x0, y0;
    logic [23:0]          nh24;
    logic signed [ZW-1:0] th0;

    always_comb begin
        dx   = $signed({1'b0, s_axis_tdata[15:0]}) - $signed({1'b0, s_axis_tdata[47:32]});
        dy   = $signed({1'b0, s_axis_tdata[31:16]}) - $signed({1'b0, s_axis_tdata[63:48]});
        x0   = {{(CW-25){dx[16]}}, dx, 8'b0};
        y0   = {{(CW-25){dy[16]}}, dy, 8'b0};
        nh24 = 24'd0 - {s_axis_tdata[79:64], 8'b0};
        // minus heading wrapped into (-half, half] turn
        th0  = $signed({{(ZW-25){nh24 > HALF24}}, nh24 > HALF24, nh24});
        n_c0 = '0;
        n_c0.side.head  = s_axis_tdata[79:64];
        n_c0.side.tw    = s_axis_tdata[90:80];
        n_c0.side.th    = (s_axis_tdata[101:91] == 11'd0) ? 11'd1 : s_axis_tdata[101:91];
        n_c0.side.ts    = s_axis_tdata[117:102];
        n_c0.side.shift = $signed(s_axis_tdata[133:118]);
        n_c0.side.tag   = s_axis_tuser;
        // bearing seed folded into the right half plane
        if (x0 < 0) begin
            n_c0.vx = -x0;
            n_c0.vy = -y0;
            n_c0.vz = ANG_HALF_Z;
        end else begin
            n_c0.vx = x0;
            n_c0.vy = y0;
            n_c0.vz = '0;
        end
        // rotation seed folded into a quarter turn
        if (th0 > ANG_QUARTER_Z) begin
            n_c0.rx = -x0;
            n_c0.ry = -y0;
            n_c0.rz = th0 - ANG_HALF_Z;
        end else if (th0 < -ANG_QUARTER_Z) begin
            n_c0.rx = -x0;
            n_c0.ry = -y0;
            n_c0.rz = th0 + ANG_HALF_Z;
        end else begin
            n_c0.rx = x0;
            n_c0.ry = y0;
            n_c0.rz = th0;
        end
    end

    t_cordic c_st [0:CORDIC_STEPS];
    logic    c_v  [0:CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            c_v[0] <= 1'b0;
        end else if (en) begin
            c_v[0] <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            c_st[0] <= n_c0;
        end
    end

    // cordic chain, one step per cell
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        bsp_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_step  (5'(k)),
            .i_valid (c_v[k]),
            .i_cell  (c_st[k]),
            .o_valid (c_v[k+1]),
            .o_cell  (c_st[k+1])
        );
    end

    // ------------------------------------------------------------------
    // post stages: angle difference, gain removal, column, divider seeds
    // ------------------------------------------------------------------
    t_side r_p1, r_p2, r_p3, r_p4;
    t_side n_p1, n_p2, n_p3, n_p4;
    logic  r_p1_v, r_p2_v, r_p3_v, r_p4_v;
    t_div  n_d0;

    logic [23:0]          u_ang;
    logic signed [44:0]   m_gain;
    logic [31:0]          m_sdts;
    logic signed [41:0]   m_drpt;
    logic [42:0]          m_nw;
    logic signed [42:0]   s_acc;
    logic [DW-1:0]        m_den;
    logic signed [21:0]   acc_hi;
    logic [20:0]          acc_lo;
    logic signed [38:0]   m_hi;
    logic [36:0]          m_lo;
    logic signed [59:0]   s_hx;
    logic signed [36:0]   lim_lo, lim_hi;
    logic [41:0]          num;
    logic [27:0]          nw_hi;

    always_comb begin
        // stage 1
        n_p1      = c_st[CORDIC_STEPS].side;
        u_ang     = c_st[CORDIC_STEPS].vz[23:0] - {c_st[CORDIC_STEPS].side.head, 8'b0};
        n_p1.d    = $signed({u_ang > HALF24, u_ang});
        m_gain    = c_st[CORDIC_STEPS].rx * INV_GAIN;
        n_p1.dq_mul = m_gain;
        m_sdts    = r_sd * c_st[CORDIC_STEPS].side.ts;
        n_p1.sdts = m_sdts;
        // stage 2
        n_p2      = r_p1;
        n_p2.dq18 = r_p1.dq_mul[44:16];
        m_drpt    = r_p1.d * $signed({1'b0, r_rpt});
        n_p2.drpt = m_drpt;
        m_nw      = r_p1.sdts * r_p1.tw;
        n_p2.nw   = {m_nw, 10'b0};
        // stage 3
        n_p3      = r_p2;
        s_acc     = $signed({6'b0, r_hrc, 24'b0}) + r_p2.drpt;
        n_p3.acc  = s_acc;
        m_den     = r_p2.dq18[DQ_W-1:0] * r_p2.th;
        n_p3.den  = m_den;
        // stage 4: column product split in two halves
        n_p4      = r_p3;
        acc_hi    = r_p3.acc[42:21];
        acc_lo    = r_p3.acc[20:0];
        m_hi      = acc_hi * $signed({1'b0, r_ppr});
        m_lo      = acc_lo * r_ppr;
        n_p4.hi_p = m_hi;
        n_p4.lo_p = m_lo;
        // stage 5: column, visibility, divider seeds
        s_hx      = $signed({r_p4.hi_p, 21'b0}) + $signed({23'b0, r_p4.lo_p});
        lim_lo    = -$signed({19'b0, r_p4.tw, 7'b0});
        lim_hi    = $signed({16'b0, r_hsw, 9'b0}) + $signed({19'b0, r_p4.tw, 7'b0});
        n_d0      = '0;
        n_d0.side = r_p4;
        n_d0.side.hx8 = s_hx[59:24];
        // column compared as a signed value against both screen limits
        n_d0.side.vis = (r_p4.dq18 > 29'sd131072) && ($signed(s_hx[59:24]) > lim_lo)
                        && ($signed(s_hx[59:24]) < lim_hi);
        num       = {r_p4.sdts, 10'b0};
        n_d0.nh   = num[QB-1:0];
        n_d0.ph   = {{(DW-17){1'b0}}, num[41:QB]};
        nw_hi     = r_p4.nw[52:QB];
        n_d0.nl   = r_p4.nw[QB-1:0];
        // width quotient beyond the divider range is clamped at the end
        n_d0.ovf  = {{(DW-28){1'b0}}, nw_hi} >= r_p4.den;
        n_d0.pw   = n_d0.ovf ? '0 : {{(DW-28){1'b0}}, nw_hi};
    end

    t_div d_st [0:QB];
    logic d_v  [0:QB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
            r_p4_v <= 1'b0;
            d_v[0] <= 1'b0;
        end else if (en) begin
            r_p1_v <= c_v[CORDIC_STEPS];
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
            r_p4_v <= r_p3_v;
            d_v[0] <= r_p4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1    <= n_p1;
            r_p2    <= n_p2;
            r_p3    <= n_p3;
            r_p4    <= n_p4;
            d_st[0] <= n_d0;
        end
    end

    // divider chain, one quotient bit per cell
    for (genvar k = 0; k < QB; k++) begin : g_div
        bsp_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (d_v[k]),
            .i_cell  (d_st[k]),
            .o_valid (d_v[k+1]),
            .o_cell  (d_st[k+1])
        );
    end

    // ------------------------------------------------------------------
    // final stage: shift product, then box assembly into the output register
    // ------------------------------------------------------------------
    logic               r_f1_v, r_f1_vis;
    logic [QB-1:0]      r_f1_ph, r_f1_pw;
    logic signed [41:0] r_f1_prod;
    logic signed [35:0] r_f1_hx8;
    logic signed [28:0] r_f1_dq18;
    logic [7:0]         r_f1_tag;
    logic [QB-1:0]      n_f1_pw;
    logic signed [41:0] n_f1_prod;

    always_comb begin
        n_f1_pw   = d_st[QB].ovf ? '1 : d_st[QB].qw;
        n_f1_prod = $signed({1'b0, d_st[QB].qh}) * d_st[QB].side.shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
        end else if (en) begin
            r_f1_v <= d_v[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_vis  <= d_st[QB].side.vis;
            r_f1_ph   <= d_st[QB].qh;
            r_f1_pw   <= n_f1_pw;
            r_f1_prod <= n_f1_prod;
            r_f1_hx8  <= d_st[QB].side.hx8;
            r_f1_dq18 <= d_st[QB].side.dq18;
            r_f1_tag  <= d_st[QB].side.tag;
        end
    end

    assign keep          = r_f1_v && r_f1_vis;
    assign en            = !(keep && r_out_valid && !m_axis_tready);
    assign s_axis_tready = en;

    logic [20:0]        dep_full;
    logic signed [28:0] left_full, top_full;
    logic [71:0]        n_out;

    always_comb begin
        dep_full  = r_f1_dq18[28:8];
        left_full = $signed(r_f1_hx8[35:8]) - $signed({13'b0, r_f1_pw[24:9]});
        top_full  = $signed({17'b0, r_hsh}) - $signed({13'b0, r_f1_ph[24:9]})
                    + $signed(r_f1_prod[41:21]);
        n_out[15:0]  = (|dep_full[20:16]) ? 16'hFFFF : dep_full[15:0];
        n_out[29:16] = sat_s14(left_full);
        n_out[43:30] = sat_s14(top_full);
        n_out[57:44] = (|r_f1_pw[24:22]) ? 14'h3FFF : r_f1_pw[21:8];
        n_out[71:58] = (|r_f1_ph[24:22]) ? 14'h3FFF : r_f1_ph[21:8];
    end

    logic [71:0] r_out_data;
    logic [7:0]  r_out_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en && keep) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && keep) begin
            r_out_data <= n_out;
            r_out_tag  <= r_f1_tag;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_tag;

`ifndef ASSERT_OFF
    // input back-pressure only comes from a stalled full output register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && keep))
        else $error("input stalled without a blocked result");

    // a visible sprite in the last stage reaches the output register
    a_result_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (keep && s_axis_tready) |=> m_axis_tvalid)
        else $error("visible result lost");

    // only sprites deeper than half a map unit leave the core
    a_min_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:0] >= 16'd512))
        else $error("result too close to viewer");
`endif
endmodule

// ===== sv/bsp_cordic_cell.sv =====
// one cordic step cell: vectoring lane for bearing, rotating lane for depth
module bsp_cordic_cell import bsp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic [4:0] i_step,
    input  logic    i_valid,
    input  t_cordic i_cell,
    output logic    o_valid,
    output t_cordic o_cell
);
    logic                 r_valid;
    t_cordic              r_cell;
    t_cordic              n_cell;
    logic signed [CW-1:0] vxs, vys, rxs, rys;
    logic signed [ZW-1:0] ang;

    always_comb begin
        vxs    = i_cell.vx >>> i_step;
        vys    = i_cell.vy >>> i_step;
        rxs    = i_cell.rx >>> i_step;
        rys    = i_cell.ry >>> i_step;
        ang    = atan_turn(i_step);
        n_cell = i_cell;
        // vectoring drives y toward zero
        if (i_cell.vy < 0) begin
            n_cell.vx = i_cell.vx - vys;
            n_cell.vy = i_cell.vy + vxs;
            n_cell.vz = i_cell.vz - ang;
        end else begin
            n_cell.vx = i_cell.vx + vys;
            n_cell.vy = i_cell.vy - vxs;
            n_cell.vz = i_cell.vz + ang;
        end
        // rotating drives the angle toward zero
        if (i_cell.rz >= 0) begin
            n_cell.rx = i_cell.rx - rys;
            n_cell.ry = i_cell.ry + rxs;
            n_cell.rz = i_cell.rz - ang;
        end else begin
            n_cell.rx = i_cell.rx + rys;
            n_cell.ry = i_cell.ry - rxs;
            n_cell.rz = i_cell.rz + ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_valid = r_valid;
    assign o_cell  = r_cell;
endmodule

// ===== sv/bsp_div_cell.sv =====
// one restoring division step cell, height and width quotients side by side
module bsp_div_cell import bsp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_div i_cell,
    output logic o_valid,
    output t_div o_cell
);
    logic          r_valid;
    t_div          r_cell;
    t_div          n_cell;
    logic [DW-1:0] den_h;
    logic [DW:0]   th_t, tw_t, dh, dw;
    logic          ge_h, ge_w;

    always_comb begin
        den_h  = {{(DW-DQ_W){1'b0}}, i_cell.side.dq18[DQ_W-1:0]};
        th_t   = {i_cell.ph, i_cell.nh[QB-1]};
        tw_t   = {i_cell.pw, i_cell.nl[QB-1]};
        dh     = th_t - {1'b0, den_h};
        dw     = tw_t - {1'b0, i_cell.side.den};
        ge_h   = th_t >= {1'b0, den_h};
        ge_w   = tw_t >= {1'b0, i_cell.side.den};
        n_cell = i_cell;
        n_cell.ph = ge_h ? dh[DW-1:0] : th_t[DW-1:0];
        n_cell.pw = ge_w ? dw[DW-1:0] : tw_t[DW-1:0];
        n_cell.nh = {i_cell.nh[QB-2:0], 1'b0};
        n_cell.nl = {i_cell.nl[QB-2:0], 1'b0};
        n_cell.qh = {i_cell.qh[QB-2:0], ge_h};
        n_cell.qw = {i_cell.qw[QB-2:0], ge_w};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_valid = r_valid;
    assign o_cell  = r_cell;
endmodule
